// ----- rtl/core/wsm_pkg.sv -----
// Shared types and constants for the star-only wildcard matcher.
// Used by every module under rtl/core; depends on nothing.
package wsm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_NAME   = 2'd1,
    OP_END    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // one item leaving the input stage this cycle
  typedef struct packed {
    logic       fire;
    op_t        op;
    logic [7:0] ch;
  } step_t;

endpackage

// ----- rtl/core/wsm_pattern.sv -----
// Pattern storage: one byte register per position, length and sticky overflow.
// Produces per-position star and literal-hit masks. Depends on wsm_pkg.
module wsm_pattern import wsm_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  step_t                  step,
  output logic [LEN_W-1:0]       len,
  output logic                   overflow,
  output logic [PATTERN_MAX-1:0] star_on,
  output logic [PATTERN_MAX-1:0] lit_hit
);

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

  logic [7:0]       store_r [PATTERN_MAX];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             do_append;

  assign do_append = step.fire && (step.op == OP_APPEND);

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (step.fire) begin
      case (step.op)
        OP_APPEND: begin
          if (len_r < LEN_FULL) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    logic in_len;

    // the write slot is the current length; a full pattern matches no slot
    always_ff @(posedge clk) begin
      if (do_append && (len_r == LEN_W'(i))) begin
        store_r[i] <= step.ch;
      end
    end

    assign in_len     = (LEN_W'(i) < len_r);
    assign star_on[i] = in_len && (store_r[i] == STAR_BYTE);
    assign lit_hit[i] = in_len && (store_r[i] != STAR_BYTE) && (store_r[i] == step.ch);
  end

  assign len      = len_r;
  assign overflow = ovf_r;

endmodule

// ----- rtl/core/wsm_nfa.sv -----
// Active-position set: keeps the set before star closure, closes it with a
// parallel-prefix network each cycle and advances it on name bytes. Uses wsm_pkg.
module wsm_nfa import wsm_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  step_t                  step,
  input  logic [LEN_W-1:0]       len,
  input  logic [PATTERN_MAX-1:0] star_on,
  input  logic [PATTERN_MAX-1:0] lit_hit,
  output logic                   matched
);

  localparam int NPOS   = PATTERN_MAX + 1;
  localparam int LEVELS = $clog2(NPOS);
  localparam logic [NPOS-1:0] RESTART = NPOS'(1);

  logic [NPOS-1:0] raw_r, raw_nxt;
  logic [NPOS-1:0] prop;
  logic [NPOS-1:0] act;
  logic [NPOS-1:0] kg [LEVELS+1];
  logic [NPOS-1:0] kp [LEVELS+1];
  logic [NPOS-1:0] adv;

  // position k is reached for free from k-1 when k-1 holds a star
  assign prop  = {star_on, 1'b0};
  assign kg[0] = raw_r;
  assign kp[0] = prop;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int D = 1 << l;
    assign kg[l+1] = kg[l] | (kp[l] & (kg[l] << D));
    assign kp[l+1] = kp[l] & (kp[l] << D);
  end

  assign act = kg[LEVELS];

  // star keeps its position, literal hit moves one ahead
  assign adv = {act[PATTERN_MAX-1:0] & lit_hit, 1'b0}
             | {1'b0, act[PATTERN_MAX-1:0] & star_on};

  always_comb begin
    raw_nxt = raw_r;
    if (step.fire) begin
      case (step.op)
        OP_NAME: raw_nxt = adv;
        default: raw_nxt = RESTART;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= RESTART;
    end else begin
      raw_r <= raw_nxt;
    end
  end

  assign matched = act[len];

endmodule

// ----- rtl/core/wildcard_star_match.sv -----
// Star-only glob matcher. Items arrive on in_valid/in_stall/in_data: op APPEND
// adds a pattern byte (dropped with a sticky overflow flag once PATTERN_MAX
// bytes are held), CLEAR empties the pattern, NAME streams one name byte, END
// closes the name. Only END produces a transfer on out_valid/out_stall/out_data,
// carrying matched and pattern_overflow. APPEND, CLEAR and END restart the
// active-position set at position zero.
// Throughput: one item per cycle while in_stall is low; every pattern position is updated in
// parallel, with star closure done by a ceil(log2(PATTERN_MAX+1))-level prefix net.
// An accepted END passes through the input register, then the result register,
// and may wait in the input register while a stalled result is held.
// Stall: a waiting result does not block pattern or name bytes; only an END
// that meets a stalled, occupied result register raises in_stall.
// Reset (rst_n low at a clock edge): empty pattern, overflow cleared, set at
// position zero, both channels empty. Pattern bytes themselves are not reset.
// Depends on wsm_pkg, wsm_pattern and wsm_nfa.
module wildcard_star_match import wsm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic                   s1_valid_r, s1_valid_nxt;
  in_item_t               s1_item_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic                   blocked;
  logic                   emit;
  step_t                  step;
  logic [LEN_W-1:0]       len;
  logic                   overflow;
  logic [PATTERN_MAX-1:0] star_on;
  logic [PATTERN_MAX-1:0] lit_hit;
  logic                   matched;

  assign blocked    = s1_valid_r && (s1_item_r.operation == OP_END)
                   && out_valid_r && out_stall;
  assign step.fire  = s1_valid_r && !blocked;
  assign step.op    = s1_item_r.operation;
  assign step.ch    = s1_item_r.char_byte;
  assign emit       = step.fire && (step.op == OP_END);
  assign in_stall   = blocked;

  assign s1_valid_nxt = blocked ? 1'b1 : in_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.matched          = matched;
      out_data_nxt.pattern_overflow = overflow;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked) begin
      s1_item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  wsm_pattern #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_pattern (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .len      (len),
    .overflow (overflow),
    .star_on  (star_on),
    .lit_hit  (lit_hit)
  );

  wsm_nfa #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_nfa (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .len     (len),
    .star_on (star_on),
    .lit_hit (lit_hit),
    .matched (matched)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("end of name did not load a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without a blocked result");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !emit) |=> !out_valid_r)
    else $error("result repeated after its transfer");

endmodule
